// ===== src/fpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the frame playout classifier.
// Used by fpc_decide, frame_playout_classifier and its checker; depends on nothing.

package fpc_pkg;

   localparam int FIELD_WIDTH          = 32;
   localparam int CNT_WIDTH            = 32;
   localparam int NUMBER_WIDTH_DEFAULT = 32;
   localparam int REQ_TDATA_WIDTH      = 3 * FIELD_WIDTH;
   // Action plus seven counters, padded up to whole bytes.
   localparam int RSP_TDATA_WIDTH      = 232;

   typedef enum logic [1:0] {
      FUNC_FRAME     = 2'd0,
      FUNC_INTERRUPT = 2'd1,
      FUNC_DRAIN     = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ACT_IGNORE  = 2'd0,
      ACT_APPEND  = 2'd1,
      ACT_REPLACE = 2'd2
   } action_type;

   typedef struct packed {
      logic started;
      logic dropped_valid;
      logic audible;
   } flags_type;

   typedef struct packed {
      logic [CNT_WIDTH-1:0] gap;
      logic [CNT_WIDTH-1:0] duplicate;
      logic [CNT_WIDTH-1:0] stale;
      logic [CNT_WIDTH-1:0] other_call;
      logic [CNT_WIDTH-1:0] midplay;
      logic [CNT_WIDTH-1:0] replaced;
      logic [CNT_WIDTH-1:0] appended;
   } counters_type;

endpackage

// ===== src/fpc_decide.sv =====
`timescale 1ns / 1ps
// Combinational decision for one event: next tracking state, counters and action.
// Depends on fpc_pkg.

module fpc_decide #(
   parameter int NUMBER_WIDTH = fpc_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  fpc_pkg::func_type                 func,
   input  logic [fpc_pkg::FIELD_WIDTH-1:0]   frame_call,
   input  logic [fpc_pkg::FIELD_WIDTH-1:0]   frame_answer,
   input  logic [fpc_pkg::FIELD_WIDTH-1:0]   frame_index,
   input  logic [fpc_pkg::FIELD_WIDTH-1:0]   call_id,
   input  logic [NUMBER_WIDTH-1:0]           cur_answer,
   input  logic [NUMBER_WIDTH-1:0]           cur_frame,
   input  logic [NUMBER_WIDTH-1:0]           dropped_answer,
   input  logic [NUMBER_WIDTH-1:0]           dropped_frame,
   input  fpc_pkg::flags_type                flags,
   input  fpc_pkg::counters_type             counters,
   output logic [NUMBER_WIDTH-1:0]           cur_answer_in,
   output logic [NUMBER_WIDTH-1:0]           cur_frame_in,
   output logic [NUMBER_WIDTH-1:0]           dropped_answer_in,
   output logic [NUMBER_WIDTH-1:0]           dropped_frame_in,
   output fpc_pkg::flags_type                flags_in,
   output fpc_pkg::counters_type             counters_in,
   output fpc_pkg::action_type               action
);

   logic [NUMBER_WIDTH-1:0] ans;
   logic [NUMBER_WIDTH-1:0] idx;
   logic [NUMBER_WIDTH-1:0] step;
   logic                    done;

   assign ans  = NUMBER_WIDTH'(frame_answer);
   assign idx  = NUMBER_WIDTH'(frame_index);
   // Only used on an append, where idx is above cur_frame, so this never wraps.
   assign step = idx - cur_frame - NUMBER_WIDTH'(1);

   always_comb begin
      cur_answer_in     = cur_answer;
      cur_frame_in      = cur_frame;
      dropped_answer_in = dropped_answer;
      dropped_frame_in  = dropped_frame;
      flags_in          = flags;
      counters_in       = counters;
      action            = fpc_pkg::ACT_IGNORE;
      done              = 1'b0;
      unique case (func)
         fpc_pkg::FUNC_FRAME: begin
            if (frame_call != call_id) begin
               counters_in.other_call = counters.other_call + 32'd1;
            end else begin
               // An older answer is only taken back if it restarts at frame zero.
               if (ans < cur_answer) begin
                  if (idx != '0) begin
                     counters_in.stale = counters.stale + 32'd1;
                     done = 1'b1;
                  end else begin
                     cur_answer_in          = ans;
                     flags_in.started       = 1'b0;
                     flags_in.dropped_valid = 1'b0;
                  end
               end
               // Tail of the answer that was interrupted locally.
               if (!done && flags_in.dropped_valid && ans == dropped_answer) begin
                  if (idx != '0 && idx >= dropped_frame) begin
                     counters_in.stale = counters.stale + 32'd1;
                     done = 1'b1;
                  end else begin
                     flags_in.dropped_valid = 1'b0;
                  end
               end
               if (!done) begin
                  if (ans > cur_answer_in || !flags_in.started) begin
                     counters_in.replaced = counters.replaced + 32'd1;
                     if (flags.audible && ans > cur_answer_in) begin
                        counters_in.midplay = counters.midplay + 32'd1;
                     end
                     flags_in.dropped_valid = 1'b0;
                     flags_in.started       = 1'b1;
                     flags_in.audible       = 1'b1;
                     cur_answer_in          = ans;
                     cur_frame_in           = idx;
                     action                 = fpc_pkg::ACT_REPLACE;
                  end else if (idx <= cur_frame) begin
                     counters_in.duplicate = counters.duplicate + 32'd1;
                  end else begin
                     // A consecutive frame adds a gap of zero.
                     counters_in.gap      = counters.gap + 32'(step);
                     counters_in.appended = counters.appended + 32'd1;
                     flags_in.audible     = 1'b1;
                     cur_frame_in         = idx;
                     action               = fpc_pkg::ACT_APPEND;
                  end
               end
            end
         end
         fpc_pkg::FUNC_INTERRUPT: begin
            if (flags.started) begin
               dropped_answer_in      = cur_answer;
               dropped_frame_in       = cur_frame;
               flags_in.dropped_valid = 1'b1;
            end
            cur_frame_in     = '0;
            flags_in.started = 1'b0;
         end
         fpc_pkg::FUNC_DRAIN: begin
            flags_in.audible = 1'b0;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== src/frame_playout_classifier.sv =====
`timescale 1ns / 1ps
// Top level of the frame playout classifier: input register, decision, result register.
// Depends on fpc_pkg and fpc_decide.

// Every accepted event gives exactly one result beat carrying the action and all seven
// counters. An event is held in the input register and the decision is then taken
// into the result register once that register is free or being taken, so a new event
// can be accepted every cycle as long as results are taken; the only loop is the update of
// the tracking state and counters. Writing the call register over the csr channel
// clears all tracking state and counters; that channel is ready only while no event is
// in flight.

module frame_playout_classifier #(
   parameter int NUMBER_WIDTH = fpc_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_tvalid,
   output logic                                  csr_tready,
   input  logic [fpc_pkg::FIELD_WIDTH-1:0]       csr_tdata,     // call_id
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [fpc_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,     // frame_call, frame_answer, frame_index
   input  logic [1:0]                            req_tuser,     // func
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // action, appended, replaced, midplay, other_call, stale, duplicate, gap counts, zero pad
   output logic [fpc_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata
);

   localparam int FW = fpc_pkg::FIELD_WIDTH;

   logic                       in_valid_ff;
   logic [1:0]                 in_func_ff;
   logic [FW-1:0]              in_call_ff;
   logic [FW-1:0]              in_answer_ff;
   logic [FW-1:0]              in_index_ff;

   logic                       out_valid_ff;
   fpc_pkg::action_type        action_ff;
   fpc_pkg::action_type        action_in;

   logic [FW-1:0]              call_id_ff;
   logic [NUMBER_WIDTH-1:0]    cur_answer_ff, cur_answer_in;
   logic [NUMBER_WIDTH-1:0]    cur_frame_ff, cur_frame_in;
   logic [NUMBER_WIDTH-1:0]    dropped_answer_ff, dropped_answer_in;
   logic [NUMBER_WIDTH-1:0]    dropped_frame_ff, dropped_frame_in;
   fpc_pkg::flags_type         flags_ff, flags_in;
   fpc_pkg::counters_type      counters_ff, counters_in;

   logic                       advance;
   logic                       csr_write;

   // The result register holds while stalled, so the decision waits with it.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_tready = !in_valid_ff && !out_valid_ff;
   assign csr_write  = csr_tvalid && csr_tready;

   fpc_decide #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_decide (
      .func              (fpc_pkg::func_type'(in_func_ff)),
      .frame_call        (in_call_ff),
      .frame_answer      (in_answer_ff),
      .frame_index       (in_index_ff),
      .call_id           (call_id_ff),
      .cur_answer        (cur_answer_ff),
      .cur_frame         (cur_frame_ff),
      .dropped_answer    (dropped_answer_ff),
      .dropped_frame     (dropped_frame_ff),
      .flags             (flags_ff),
      .counters          (counters_ff),
      .cur_answer_in     (cur_answer_in),
      .cur_frame_in      (cur_frame_in),
      .dropped_answer_in (dropped_answer_in),
      .dropped_frame_in  (dropped_frame_in),
      .flags_in          (flags_in),
      .counters_in       (counters_in),
      .action            (action_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff   <= req_tuser;
         in_call_ff   <= req_tdata[FW-1:0];
         in_answer_ff <= req_tdata[2*FW-1:FW];
         in_index_ff  <= req_tdata[3*FW-1:2*FW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         action_ff <= action_in;
      end
   end

   // The counters double as the result payload; they only move when a beat is loaded or cleared.
   always_ff @(posedge clock) begin
      if (reset) begin
         call_id_ff        <= '0;
         cur_answer_ff     <= '0;
         cur_frame_ff      <= '0;
         dropped_answer_ff <= '0;
         dropped_frame_ff  <= '0;
         flags_ff          <= '0;
         counters_ff       <= '0;
      end else if (csr_write) begin
         call_id_ff        <= csr_tdata;
         cur_answer_ff     <= '0;
         cur_frame_ff      <= '0;
         dropped_answer_ff <= '0;
         dropped_frame_ff  <= '0;
         flags_ff          <= '0;
         counters_ff       <= '0;
      end else if (advance) begin
         cur_answer_ff     <= cur_answer_in;
         cur_frame_ff      <= cur_frame_in;
         dropped_answer_ff <= dropped_answer_in;
         dropped_frame_ff  <= dropped_frame_in;
         flags_ff          <= flags_in;
         counters_ff       <= counters_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0,
                        counters_ff.gap,
                        counters_ff.duplicate,
                        counters_ff.stale,
                        counters_ff.other_call,
                        counters_ff.midplay,
                        counters_ff.replaced,
                        counters_ff.appended,
                        action_ff};

endmodule

// ===== src/fpc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the frame playout classifier, bound to the top level.
// Depends on fpc_pkg and frame_playout_classifier.

module fpc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  csr_tvalid,
   input logic                                  csr_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [fpc_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata
);

   // Reset leaves no result pending and every counter at zero.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && rsp_tdata[225:2] == '0)
      else $error("state not cleared after reset");

   // A call register write clears all counters and happens with nothing in flight.
   assert property (@(posedge clock) disable iff (reset)
      csr_tvalid && csr_tready |=> !rsp_tvalid && rsp_tdata[225:2] == '0)
      else $error("counters not cleared by call register write");

   // The action field never carries the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("invalid action code");

   // A stalled result beat stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

endmodule

bind frame_playout_classifier fpc_checker u_fpc_checker (
   .clock      (clock),
   .reset      (reset),
   .csr_tvalid (csr_tvalid),
   .csr_tready (csr_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for frame_playout_classifier: directed and random event streams,
// with a scoreboard class that predicts the action and all seven counters of every beat.
// Depends on fpc_pkg and the frame_playout_classifier RTL.

module testbench;

   localparam logic [1:0]  FUNC_UNUSED      = 2'd3;
   localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;
   localparam int          RANDOM_PER_PHASE = 608;
   localparam int          DRAIN_EVERY      = 150;
   localparam int          WATCHDOG_LIMIT   = 1000;

   typedef struct {
      fpc_pkg::action_type   action;
      fpc_pkg::counters_type counts;
   } report_type;

   class playout_scoreboard;
      logic [31:0]           call_id;
      logic [31:0]           cur_answer;
      logic [31:0]           cur_frame;
      logic [31:0]           dropped_answer;
      logic [31:0]           dropped_frame;
      logic                  started;
      logic                  dropped_valid;
      logic                  audible;
      fpc_pkg::counters_type counts;
      report_type            awaited[$];
      int                    errors;
      int                    results;
      int                    action_seen[3];

      function new();
         set_call('0);
      endfunction

      // A call register write wipes all tracking state and counters.
      function void set_call(logic [31:0] id);
         call_id        = id;
         cur_answer     = '0;
         cur_frame      = '0;
         dropped_answer = '0;
         dropped_frame  = '0;
         started        = 1'b0;
         dropped_valid  = 1'b0;
         audible        = 1'b0;
         counts         = '0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function fpc_pkg::action_type classify_frame(logic [31:0] fcall, logic [31:0] ans,
                                                   logic [31:0] idx);
         if (fcall != call_id) begin
            counts.other_call = counts.other_call + 32'd1;
            return fpc_pkg::ACT_IGNORE;
         end
         // An older answer only gets through as a restart at frame zero.
         if (ans < cur_answer) begin
            if (idx != 0) begin
               counts.stale = counts.stale + 32'd1;
               return fpc_pkg::ACT_IGNORE;
            end
            cur_answer    = ans;
            started       = 1'b0;
            dropped_valid = 1'b0;
         end
         // The tail of a locally abandoned answer stays silent.
         if (dropped_valid && ans == dropped_answer) begin
            if (idx != 0 && idx >= dropped_frame) begin
               counts.stale = counts.stale + 32'd1;
               return fpc_pkg::ACT_IGNORE;
            end
            dropped_valid = 1'b0;
         end
         if (ans > cur_answer || !started) begin
            counts.replaced = counts.replaced + 32'd1;
            if (audible && ans > cur_answer)
               counts.midplay = counts.midplay + 32'd1;
            dropped_valid = 1'b0;
            cur_answer    = ans;
            cur_frame     = idx;
            started       = 1'b1;
            audible       = 1'b1;
            return fpc_pkg::ACT_REPLACE;
         end
         if (idx <= cur_frame) begin
            counts.duplicate = counts.duplicate + 32'd1;
            return fpc_pkg::ACT_IGNORE;
         end
         audible = 1'b1;
         // Here idx > cur_frame, so cur_frame + 1 cannot wrap.
         if (idx > cur_frame + 32'd1)
            counts.gap = counts.gap + (idx - cur_frame - 32'd1);
         cur_frame       = idx;
         counts.appended = counts.appended + 32'd1;
         return fpc_pkg::ACT_APPEND;
      endfunction

      function void note_event(logic [1:0] func,
                               logic [fpc_pkg::REQ_TDATA_WIDTH-1:0] data);
         report_type r;
         r.action = fpc_pkg::ACT_IGNORE;
         case (func)
            fpc_pkg::FUNC_FRAME: begin
               r.action = classify_frame(data[31:0], data[63:32], data[95:64]);
            end
            fpc_pkg::FUNC_INTERRUPT: begin
               if (started) begin
                  dropped_answer = cur_answer;
                  dropped_frame  = cur_frame;
                  dropped_valid  = 1'b1;
               end
               cur_frame = '0;
               started   = 1'b0;
            end
            fpc_pkg::FUNC_DRAIN: begin
               audible = 1'b0;
            end
            default: ;
         endcase
         r.counts = counts;
         awaited.push_back(r);
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= 10)
            $display("mismatch on %s at beat %0d: expected %h, got %h",
                     what, results, want, got);
      endfunction

      function void check_result(logic [fpc_pkg::RSP_TDATA_WIDTH-1:0] beat);
         report_type            r;
         fpc_pkg::counters_type got;
         string                 names[7] = '{"appended", "replaced", "midplay",
                                             "other_call", "stale", "duplicate", "gap"};
         results++;
         if (awaited.size() == 0) begin
            flag("unexpected beat", '0, '0);
            return;
         end
         r   = awaited.pop_front();
         got = beat[2 +: 7*fpc_pkg::CNT_WIDTH];
         action_seen[r.action]++;
         if (beat[1:0] != r.action)
            flag("action", 32'(r.action), 32'(beat[1:0]));
         for (int k = 0; k < 7; k++)
            if (got[k*fpc_pkg::CNT_WIDTH +: fpc_pkg::CNT_WIDTH] !=
                r.counts[k*fpc_pkg::CNT_WIDTH +: fpc_pkg::CNT_WIDTH])
               flag(names[k], r.counts[k*fpc_pkg::CNT_WIDTH +: fpc_pkg::CNT_WIDTH],
                    got[k*fpc_pkg::CNT_WIDTH +: fpc_pkg::CNT_WIDTH]);
      endfunction
   endclass

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                csr_tvalid = 1'b0;
   logic                                csr_tready;
   logic [fpc_pkg::FIELD_WIDTH-1:0]     csr_tdata  = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [fpc_pkg::REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic [1:0]                          req_tuser  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [fpc_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;

   playout_scoreboard book;
   int                send_idle_pct = 16;
   int                recv_idle_pct = 49;
   int                idle_cycles   = 0;
   logic [31:0]       active_call   = '0;

   frame_playout_classifier u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Every handshake is observed here at the edge where it happens.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            book.check_result(rsp_tdata);
         if (csr_tvalid && csr_tready)
            book.set_call(csr_tdata);
         if (req_tvalid && req_tready)
            book.note_event(req_tuser, req_tdata);
         if ((rsp_tvalid && rsp_tready) || (csr_tvalid && csr_tready) ||
             (req_tvalid && req_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      do @(posedge clock); while (idle_cycles < WATCHDOG_LIMIT);
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("frame_playout_classifier regression: fail");
      $finish;
   end

   task automatic send_event(input logic [1:0] func, input logic [31:0] call,
                             input logic [31:0] ans, input logic [31:0] idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {idx, ans, call};
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds the sender off until every predicted beat has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   task automatic write_call(input logic [31:0] id);
      active_call = id;
      csr_tvalid <= 1'b1;
      csr_tdata  <= id;
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
   endtask

   // Mostly one well-formed stream of answers on the active call, with repeats, gaps,
   // stragglers, restarts, interrupts, drains and unused function codes mixed in, plus foreign and random frames.
   task automatic run_random(input int count, input logic [31:0] first_answer);
      logic [31:0] answer_now;
      logic [31:0] frame_now;
      logic [31:0] call;
      logic [31:0] ans;
      logic [31:0] idx;
      logic [1:0]  func;
      int          r;
      int          s;
      answer_now = first_answer;
      frame_now  = '0;
      for (int n = 0; n < count; n++) begin
         if (n > 0 && n % DRAIN_EVERY == 0)
            settle();
         call = $urandom;
         ans  = $urandom;
         idx  = $urandom;
         r    = $urandom_range(0, 99);
         if (r < 5)
            func = fpc_pkg::FUNC_INTERRUPT;
         else if (r < 10)
            func = fpc_pkg::FUNC_DRAIN;
         else if (r < 11)
            func = FUNC_UNUSED;
         else begin
            func = fpc_pkg::FUNC_FRAME;
            if (r < 16) begin
               if (call == active_call)
                  call = ~call;
            end else if (r >= 19) begin
               call = active_call;
               s    = $urandom_range(0, 99);
               if (s < 60)
                  frame_now = frame_now + 32'd1;
               else if (s < 68)
                  frame_now = frame_now + $urandom_range(2, 6);
               else if (s < 70)
                  frame_now = frame_now + $urandom;
               else if (s < 82) begin
                  answer_now = answer_now + $urandom_range(1, 3);
                  frame_now  = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(1, 3));
               end else if (s < 85) begin
                  answer_now = answer_now - 32'd1;
                  frame_now  = '0;
               end
               ans = answer_now;
               idx = frame_now;
               if (s >= 85 && s < 93)
                  idx = frame_now - $urandom_range(0, 2);
               else if (s >= 93) begin
                  ans = answer_now - $urandom_range(1, 2);
                  idx = $urandom_range(0, 4);
               end
            end
         end
         send_event(func, call, ans, idx);
      end
   endtask

   initial begin
      book = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_call('0);
      send_event(FUNC_UNUSED,             ALL_ONES, ALL_ONES, ALL_ONES);
      send_event(fpc_pkg::FUNC_INTERRUPT, '0, '0, '0);
      send_event(fpc_pkg::FUNC_DRAIN,     ALL_ONES, ALL_ONES, ALL_ONES);
      send_event(fpc_pkg::FUNC_FRAME,     ALL_ONES, ALL_ONES, ALL_ONES);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd5, 32'd0);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd5, 32'd1);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd5, 32'd1);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd5, 32'd4);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd5, ALL_ONES);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd3, 32'd2);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd6, 32'd0);
      send_event(fpc_pkg::FUNC_DRAIN,     '0, '0, '0);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd7, 32'd0);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd7, 32'd1);
      send_event(fpc_pkg::FUNC_INTERRUPT, '0, '0, '0);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd7, 32'd2);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd7, 32'd1);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd7, 32'd0);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd7, 32'd3);
      // A second huge gap pushes the gap counter past its wrap point.
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd7, ALL_ONES);
      send_event(fpc_pkg::FUNC_FRAME,     '0, 32'd2, 32'd0);
      send_event(fpc_pkg::FUNC_FRAME,     '0, ALL_ONES, ALL_ONES);
      send_event(fpc_pkg::FUNC_FRAME,     '0, ALL_ONES, 32'd0);
      send_event(fpc_pkg::FUNC_INTERRUPT, ALL_ONES, ALL_ONES, ALL_ONES);
      send_event(fpc_pkg::FUNC_FRAME,     '0, ALL_ONES, 32'd5);
      send_event(FUNC_UNUSED,             $urandom, $urandom, $urandom);
      settle();

      write_call(ALL_ONES);
      run_random(RANDOM_PER_PHASE, 32'hFFFF_FFF0);
      settle();

      send_idle_pct = 49;
      recv_idle_pct = 16;
      write_call($urandom);
      run_random(RANDOM_PER_PHASE, '0);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_call($urandom);
      run_random(RANDOM_PER_PHASE, $urandom);
      settle();
      repeat (6) @(posedge clock);

      $display("%0d result beats over four call settings: %0d appends, %0d replaces",
               book.results, book.action_seen[fpc_pkg::ACT_APPEND],
               book.action_seen[fpc_pkg::ACT_REPLACE]);
      $display("%0d ignores and %0d field mismatches in total",
               book.action_seen[fpc_pkg::ACT_IGNORE], book.errors);
      if (book.errors == 0)
         $display("frame_playout_classifier regression: pass");
      else
         $display("frame_playout_classifier regression: fail");
      $finish;
   end

endmodule
